>>> hw/rtl/hmac_sha256_key_derivation_core_macros.svh
// Assertion macros for the key derivation core.
`ifndef HMAC_SHA256_KEY_DERIVATION_CORE_MACROS_SVH
`define HMAC_SHA256_KEY_DERIVATION_CORE_MACROS_SVH
`ifndef SYNTH
`define HKD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define HKD_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HKD_ASSERT(label, clk, rst_n, prop)
`define HKD_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> hw/rtl/hkd_pkg.sv
// ----------------------------------------------------------------------------
// hkd_pkg
// Shared constants, types and functions for the key derivation core.
// ----------------------------------------------------------------------------
package hkd_pkg;

    localparam int Rounds = 64;
    localparam int RoundW = $clog2(Rounds);

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;
    localparam logic [31:0] LABEL = 32'h07D40414;
    localparam logic [31:0] OUT_LEN = 32'h00000020;
    localparam logic [7:0] COUNTER = 8'h01;
    // bit lengths of the padded second blocks: 64+26 and 64+32 bytes
    localparam logic [31:0] INNER_BITS = 32'd720;
    localparam logic [31:0] OUTER_BITS = 32'd768;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    typedef struct packed {
        logic start;
        logic [511:0] blk;
        logic [255:0] h;
    } comp_req_t;

    function automatic logic [31:0] round_k(input logic [RoundW-1:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> hw/rtl/hkd_compress.sv
// ----------------------------------------------------------------------------
// hkd_compress
// SHA-256 compression, one round per cycle over a rolling message schedule.
// ----------------------------------------------------------------------------
`include "hmac_sha256_key_derivation_core_macros.svh"

module hkd_compress
(
    input  logic                clk,
    input  logic                rst_n,
    input  hkd_pkg::comp_req_t  req,
    output logic                done,
    output logic [255:0]        h_out
);

    logic                       run_reg;
    logic [hkd_pkg::RoundW-1:0] rnd_reg;
    logic [31:0]                w_reg [16];
    logic [31:0]                a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg;
    logic [255:0]               h_reg;
    logic                       done_reg;

    logic [31:0] s0, s1, w_new, t1, t2, ch, maj, ep0, ep1;

    always_comb
    begin
        s0 = hkd_pkg::rotr(w_reg[1], 7) ^ hkd_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = hkd_pkg::rotr(w_reg[14], 17) ^ hkd_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        ep1 = hkd_pkg::rotr(e_reg, 6) ^ hkd_pkg::rotr(e_reg, 11) ^ hkd_pkg::rotr(e_reg, 25);
        ch = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1 = hh_reg + ep1 + ch + hkd_pkg::round_k(rnd_reg) + w_reg[0];
        ep0 = hkd_pkg::rotr(a_reg, 2) ^ hkd_pkg::rotr(a_reg, 13) ^ hkd_pkg::rotr(a_reg, 22);
        maj = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2 = ep0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (run_reg)
            begin
                rnd_reg <= rnd_reg + 1'b1;
                if (rnd_reg == hkd_pkg::RoundW'(hkd_pkg::Rounds - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            for (int i = 0; i < 16; i++)
                w_reg[i] <= req.blk[511 - 32*i -: 32];
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg} <= req.h;
            h_reg <= req.h;
        end
        else if (run_reg)
        begin
            // slide the schedule window one word
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            hh_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    assign done = done_reg;
    assign h_out = {h_reg[255:224] + a_reg, h_reg[223:192] + b_reg,
                    h_reg[191:160] + c_reg, h_reg[159:128] + d_reg,
                    h_reg[127:96] + e_reg, h_reg[95:64] + f_reg,
                    h_reg[63:32] + g_reg, h_reg[31:0] + hh_reg};

    `HKD_ASSERT(a_done_after_run, clk, rst_n, done_reg |-> $past(run_reg))
    `HKD_ASSERT(a_no_start_running, clk, rst_n, req.start |-> !run_reg)
    `HKD_ASSERT(a_done_idle, clk, rst_n, done_reg |-> !run_reg)

endmodule

>>> hw/rtl/hmac_sha256_key_derivation_core.sv
// ----------------------------------------------------------------------------
// hmac_sha256_key_derivation_core
// HMAC-SHA256 counter-mode key derivation of one 256-bit key per word.
// ----------------------------------------------------------------------------
// Usage: drive key_word0..3 and seed_high/low with start high while busy is
// low; the word is taken at that edge. busy then stays high while one shared
// SHA-256 round unit runs four compressions of 64 rounds (inner key block,
// inner message block, outer key block, outer digest block).
// Each compression takes a kick edge, a load edge and one edge per round; the
// start edge serves as the first one's kick, and done is registered after the
// last round of the outer digest block.
// done is high for one cycle with derived_word0..3 valid, and busy drops in
// that same cycle, so a new start may be taken at the edge that ends it.
// A new word is taken only once the last is done; the single round unit does
// one round per cycle.
// The receiver cannot stall: done is shown for one cycle only.
// Reset clears the sequencer; no state is kept between words.
// ----------------------------------------------------------------------------
`include "hmac_sha256_key_derivation_core_macros.svh"

module hmac_sha256_key_derivation_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] key_word0,
    input  logic [63:0] key_word1,
    input  logic [63:0] key_word2,
    input  logic [63:0] key_word3,
    input  logic [63:0] seed_high,
    input  logic [63:0] seed_low,
    output logic        done,
    output logic [63:0] derived_word0,
    output logic [63:0] derived_word1,
    output logic [63:0] derived_word2,
    output logic [63:0] derived_word3
);

    typedef enum logic [2:0] {ST_IDLE, ST_IN1, ST_IN2, ST_OUT1, ST_OUT2} state_t;

    state_t       state_reg;
    logic         kick_reg;
    logic [255:0] key_reg;
    logic [127:0] seed_reg;
    logic [255:0] mid_reg;
    logic [255:0] out_reg;
    logic         done_reg;

    hkd_pkg::comp_req_t req;
    logic               c_done;
    logic [255:0]       c_h;

    function automatic logic [511:0] pad_key(input logic [255:0] k, input logic [7:0] p);
        return {k ^ {32{p}}, {32{p}}};
    endfunction

    always_comb
    begin
        req.start = kick_reg;
        req.blk = '0;
        req.h = hkd_pkg::INIT_H;
        case (state_reg)
            ST_IN1: req.blk = pad_key(key_reg, hkd_pkg::IPAD);
            ST_IN2:
            begin
                req.h = mid_reg;
                req.blk = {hkd_pkg::LABEL, 8'h00, seed_reg, hkd_pkg::OUT_LEN,
                           hkd_pkg::COUNTER, 8'h80, 264'd0, hkd_pkg::INNER_BITS};
            end
            ST_OUT1: req.blk = pad_key(key_reg, hkd_pkg::OPAD);
            ST_OUT2:
            begin
                req.h = out_reg;
                req.blk = {mid_reg, 8'h80, 216'd0, hkd_pkg::OUTER_BITS};
            end
            default: req.blk = '0;
        endcase
    end

    hkd_compress u_comp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .done  (c_done),
        .h_out (c_h)
    );

    // mid_reg holds inner chain, then inner digest; out_reg the outer chain, then the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kick_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            kick_reg <= 1'b0;
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (start)
                    begin
                        state_reg <= ST_IN1;
                        kick_reg  <= 1'b1;
                    end
                ST_IN1:
                    if (c_done)
                    begin
                        state_reg <= ST_IN2;
                        kick_reg  <= 1'b1;
                    end
                ST_IN2:
                    if (c_done)
                    begin
                        state_reg <= ST_OUT1;
                        kick_reg  <= 1'b1;
                    end
                ST_OUT1:
                    if (c_done)
                    begin
                        state_reg <= ST_OUT2;
                        kick_reg  <= 1'b1;
                    end
                ST_OUT2:
                    if (c_done)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            key_reg  <= {key_word0, key_word1, key_word2, key_word3};
            seed_reg <= {seed_high, seed_low};
        end
        if (c_done)
        begin
            case (state_reg)
                ST_IN1:  mid_reg <= c_h;
                ST_IN2:  mid_reg <= c_h;
                ST_OUT1: out_reg <= c_h;
                ST_OUT2: out_reg <= c_h;
                default: out_reg <= out_reg;
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign derived_word0 = out_reg[255:192];
    assign derived_word1 = out_reg[191:128];
    assign derived_word2 = out_reg[127:64];
    assign derived_word3 = out_reg[63:0];

    `HKD_ASSERT(a_done_idle, clk, rst_n, done_reg |-> state_reg == ST_IDLE)
    `HKD_ASSERT(a_done_from_last, clk, rst_n, done_reg |-> $past(state_reg) == ST_OUT2)
    `HKD_ASSERT(a_kick_busy, clk, rst_n, kick_reg |-> busy)

endmodule
